// File: design/dmc_pkg.sv
// Shared constants, codes and helpers for the maze carver.
`timescale 1ns / 1ps

package dmc_pkg;

    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    // Width of the generation tag kept next to each wall word.
    localparam int EPOCH_W = 6;

    localparam logic [3:0] ALL_WALLS = 4'hF;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [2:0] EV_STARTED     = 3'd0;
    localparam logic [2:0] EV_CARVED      = 3'd1;
    localparam logic [2:0] EV_BACKTRACKED = 3'd2;
    localparam logic [2:0] EV_FINISHED    = 3'd3;
    localparam logic [2:0] EV_IGNORED     = 3'd4;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [1:0] CFG_NUM_ROWS  = 2'd0;
    localparam logic [1:0] CFG_NUM_COLS  = 2'd1;
    localparam logic [1:0] CFG_START_ROW = 2'd2;
    localparam logic [1:0] CFG_START_COL = 2'd3;

    // Byte mod 3: base-4 digit sum keeps the residue.
    function automatic logic [1:0] mod3_u8(input logic [7:0] v);
        logic [3:0] s;
        logic [1:0] r;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        case (s) inside
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12:  r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13: r = 2'd1;
            default:                        r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

// File: design/dmc_wall_mem.sv
// Wall store: one synchronous RAM of tagged wall words, stale tags read as all walls up.
`timescale 1ns / 1ps

module dmc_wall_mem #(
    parameter int MAX_ROWS = dmc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = dmc_pkg::DEF_MAX_COLS
) (
    input  logic                                   clk,
    input  logic [dmc_pkg::EPOCH_W-1:0]            epoch,
    input  logic                                   wr_en,
    input  logic                                   wr_clear,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   wr_addr,
    input  logic [3:0]                             wr_walls,
    input  logic                                   rd_en,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   rd_addr,
    output logic [3:0]                             rd_walls
);

    localparam int CELL_SLOTS = MAX_ROWS * MAX_COLS;
    localparam int WORD_W     = dmc_pkg::EPOCH_W + 4;

    logic [WORD_W-1:0] mem [CELL_SLOTS];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (wr_clear)
                mem[wr_addr] <= {{dmc_pkg::EPOCH_W{1'b0}}, dmc_pkg::ALL_WALLS};
            else
                mem[wr_addr] <= {epoch, wr_walls};
        end
        if (rd_en)
            rd_word_reg <= mem[rd_addr];
    end

    // A word from an older generation was never touched since the last start.
    assign rd_walls = (rd_word_reg[WORD_W-1:4] == epoch) ? rd_word_reg[3:0]
                                                         : dmc_pkg::ALL_WALLS;

endmodule

// File: design/dfs_maze_carver_top.sv
// Depth-first maze carver: control sequencer, path stack RAM and result register.
// Start: done comes after the start and init states; the first start after reset, and every
//   63rd start after that, first sweeps every word of the wall RAM in the clear state.
// Step: done comes in the cycle after the request when ignored or finished at once; otherwise
//   after the wall RAM read states, a decide state (where it may finish) and a write or pop state.
// A new request is taken in the cycle done is high. done is a one-cycle strobe.
// rst_n clears control state asynchronously; RAM contents are not reset.
`timescale 1ns / 1ps

module dfs_maze_carver_top #(
    parameter int MAX_ROWS = dmc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = dmc_pkg::DEF_MAX_COLS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [7:0]  rand_value,
    output logic        done,
    output logic [2:0]  event_res,
    output logic [9:0]  from_cell,
    output logic [9:0]  to_cell,
    output logic [1:0]  direction,
    output logic [10:0] cells_visited,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int CELL_SLOTS = MAX_ROWS * MAX_COLS;
    localparam int CELL_W     = $clog2(CELL_SLOTS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int RCNT_W     = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W     = $clog2(MAX_COLS + 1);
    localparam int VIS_W      = $clog2(CELL_SLOTS + 1);
    localparam int STK_SLOTS  = CELL_SLOTS + 1;
    localparam int STK_AW     = $clog2(STK_SLOTS);
    localparam int CNT_W      = $clog2(STK_SLOTS + 1);
    localparam int STK_W      = ROW_W + COL_W;
    localparam int EW         = dmc_pkg::EPOCH_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_INIT   = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;
    localparam logic [2:0] S_WR2    = 3'd6;
    localparam logic [2:0] S_POP    = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [5:0]        num_rows_reg, num_rows_next;
    logic [5:0]        num_cols_reg, num_cols_next;
    logic [4:0]        start_row_reg, start_row_next;
    logic [4:0]        start_col_reg, start_col_next;
    logic [RCNT_W-1:0] act_rows_reg, act_rows_next;
    logic [CCNT_W-1:0] act_cols_reg, act_cols_next;
    logic [VIS_W-1:0]  total_reg, total_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [CELL_W-1:0] cur_cell_reg, cur_cell_next;
    logic [VIS_W-1:0]  vis_reg, vis_next;
    logic [CNT_W-1:0]  stk_cnt_reg, stk_cnt_next;
    logic              running_reg, running_next;
    logic [EW-1:0]     epoch_reg, epoch_next;
    logic [CELL_W-1:0] clr_addr_reg, clr_addr_next;
    logic [2:0]        rd_k_reg, rd_k_next;
    logic [3:0]        cur_walls_reg, cur_walls_next;
    logic [3:0]        mask_reg, mask_next;
    logic [7:0]        rnd_reg, rnd_next;
    logic [1:0]        dir_reg, dir_next;
    logic              done_reg, done_next;
    logic [2:0]        event_reg, event_next;
    logic [9:0]        from_reg, from_next;
    logic [9:0]        to_reg, to_next;
    logic [1:0]        dir_out_reg, dir_out_next;
    logic [10:0]       vis_out_reg, vis_out_next;

    logic              accept;
    logic [RCNT_W-1:0] rows_clamp;
    logic [CCNT_W-1:0] cols_clamp;
    logic [3:0]        in_grid;
    logic [CELL_W-1:0] nbr_addr [4];
    logic [ROW_W-1:0]  calc_row;
    logic [COL_W-1:0]  calc_col;
    logic [CELL_W-1:0] cell_calc;
    logic [2:0]        cand_cnt;
    logic [1:0]        pick;
    logic [1:0]        pick_dir;
    logic [2:0]        seen;
    logic              found;

    logic              wm_we, wm_clear, wm_re;
    logic [CELL_W-1:0] wm_waddr, wm_raddr;
    logic [3:0]        wm_wwalls, wm_rwalls;

    logic              stk_we, stk_re;
    logic [STK_AW-1:0] stk_waddr, stk_raddr;
    logic [STK_W-1:0]  stk_wdata;
    logic [STK_W-1:0]  stk_mem [STK_SLOTS];
    logic [STK_W-1:0]  stk_rd_reg;

    dmc_wall_mem #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_wall_mem (
        .clk      (clk),
        .epoch    (epoch_reg),
        .wr_en    (wm_we),
        .wr_clear (wm_clear),
        .wr_addr  (wm_waddr),
        .wr_walls (wm_wwalls),
        .rd_en    (wm_re),
        .rd_addr  (wm_raddr),
        .rd_walls (wm_rwalls)
    );

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rd_reg <= stk_mem[stk_raddr];
    end

    assign busy          = (state_reg != S_IDLE);
    assign accept        = start && !busy;
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign event_res     = event_reg;
    assign from_cell     = from_reg;
    assign to_cell       = to_reg;
    assign direction     = dir_out_reg;
    assign cells_visited = vis_out_reg;

    always_comb
    begin
        if (num_rows_reg == 6'd0)
            rows_clamp = RCNT_W'(1);
        else if (int'(num_rows_reg) > MAX_ROWS)
            rows_clamp = RCNT_W'(MAX_ROWS);
        else
            rows_clamp = RCNT_W'(num_rows_reg);
        if (num_cols_reg == 6'd0)
            cols_clamp = CCNT_W'(1);
        else if (int'(num_cols_reg) > MAX_COLS)
            cols_clamp = CCNT_W'(MAX_COLS);
        else
            cols_clamp = CCNT_W'(num_cols_reg);
    end

    assign in_grid[dmc_pkg::DIR_UP]    = (cur_row_reg != '0);
    assign in_grid[dmc_pkg::DIR_DOWN]  = (cur_row_reg != ROW_W'(act_rows_reg - RCNT_W'(1)));
    assign in_grid[dmc_pkg::DIR_LEFT]  = (cur_col_reg != '0);
    assign in_grid[dmc_pkg::DIR_RIGHT] = (cur_col_reg != COL_W'(act_cols_reg - CCNT_W'(1)));

    assign nbr_addr[dmc_pkg::DIR_UP]    = cur_cell_reg - CELL_W'(act_cols_reg);
    assign nbr_addr[dmc_pkg::DIR_DOWN]  = cur_cell_reg + CELL_W'(act_cols_reg);
    assign nbr_addr[dmc_pkg::DIR_LEFT]  = cur_cell_reg - CELL_W'(1);
    assign nbr_addr[dmc_pkg::DIR_RIGHT] = cur_cell_reg + CELL_W'(1);

    // Row-major index; operands come from the popped stack entry or the start cell.
    assign calc_row  = (state_reg == S_POP) ? stk_rd_reg[STK_W-1:COL_W] : cur_row_reg;
    assign calc_col  = (state_reg == S_POP) ? stk_rd_reg[COL_W-1:0] : cur_col_reg;
    assign cell_calc = CELL_W'(CELL_W'(calc_row) * CELL_W'(act_cols_reg))
                       + CELL_W'(calc_col);

    always_comb
    begin
        cand_cnt = 3'($countones(mask_reg));
        case (cand_cnt)
            3'd2:    pick = {1'b0, rnd_reg[0]};
            3'd3:    pick = dmc_pkg::mod3_u8(rnd_reg);
            3'd4:    pick = rnd_reg[1:0];
            default: pick = 2'd0;
        endcase
        pick_dir = dmc_pkg::DIR_UP;
        seen     = 3'd0;
        found    = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (mask_reg[i] && !found)
            begin
                if (seen == {1'b0, pick})
                begin
                    pick_dir = 2'(i);
                    found    = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        num_rows_next  = num_rows_reg;
        num_cols_next  = num_cols_reg;
        start_row_next = start_row_reg;
        start_col_next = start_col_reg;
        act_rows_next  = act_rows_reg;
        act_cols_next  = act_cols_reg;
        total_next     = total_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_cell_next  = cur_cell_reg;
        vis_next       = vis_reg;
        stk_cnt_next   = stk_cnt_reg;
        running_next   = running_reg;
        epoch_next     = epoch_reg;
        clr_addr_next  = clr_addr_reg;
        rd_k_next      = rd_k_reg;
        cur_walls_next = cur_walls_reg;
        mask_next      = mask_reg;
        rnd_next       = rnd_reg;
        dir_next       = dir_reg;
        done_next      = 1'b0;
        event_next     = event_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        dir_out_next   = dir_out_reg;
        vis_out_next   = vis_out_reg;

        wm_we     = 1'b0;
        wm_clear  = 1'b0;
        wm_waddr  = cur_cell_reg;
        wm_wwalls = dmc_pkg::ALL_WALLS;
        wm_re     = 1'b0;
        wm_raddr  = cur_cell_reg;
        stk_we    = 1'b0;
        stk_waddr = stk_cnt_reg[STK_AW-1:0];
        stk_wdata = {cur_row_reg, cur_col_reg};
        stk_re    = 1'b0;
        stk_raddr = STK_AW'(stk_cnt_reg - CNT_W'(1));

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dmc_pkg::CFG_NUM_ROWS:  num_rows_next  = cfg_data;
                dmc_pkg::CFG_NUM_COLS:  num_cols_next  = cfg_data;
                dmc_pkg::CFG_START_ROW: start_row_next = cfg_data[4:0];
                dmc_pkg::CFG_START_COL: start_col_next = cfg_data[4:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rnd_next     = rand_value;
                    from_next    = 10'(cur_cell_reg);
                    to_next      = 10'(cur_cell_reg);
                    dir_out_next = dmc_pkg::DIR_UP;
                    if (req_type == dmc_pkg::REQ_START)
                    begin
                        act_rows_next = rows_clamp;
                        act_cols_next = cols_clamp;
                        // Tag wrap or first use: sweep the RAM back to generation 0.
                        if (epoch_reg == '0 || epoch_reg == {EW{1'b1}})
                        begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EW'(1);
                            state_next = S_START;
                        end
                    end
                    else if (!running_reg)
                    begin
                        done_next    = 1'b1;
                        event_next   = dmc_pkg::EV_IGNORED;
                        vis_out_next = 11'(vis_reg);
                    end
                    else if (vis_reg >= total_reg || VIS_W'(cur_cell_reg) >= total_reg)
                    begin
                        vis_next     = total_reg;
                        running_next = 1'b0;
                        done_next    = 1'b1;
                        event_next   = dmc_pkg::EV_FINISHED;
                        vis_out_next = 11'(total_reg);
                    end
                    else
                    begin
                        rd_k_next  = 3'd0;
                        state_next = S_READ;
                    end
                end
            end

            S_CLEAR:
            begin
                wm_we    = 1'b1;
                wm_clear = 1'b1;
                wm_waddr = clr_addr_reg;
                if (clr_addr_reg == CELL_W'(CELL_SLOTS - 1))
                begin
                    epoch_next = EW'(1);
                    state_next = S_START;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + CELL_W'(1);
                end
            end

            S_START:
            begin
                if (int'(start_row_reg) > int'(act_rows_reg) - 1)
                    cur_row_next = ROW_W'(act_rows_reg - RCNT_W'(1));
                else
                    cur_row_next = ROW_W'(start_row_reg);
                if (int'(start_col_reg) > int'(act_cols_reg) - 1)
                    cur_col_next = COL_W'(act_cols_reg - CCNT_W'(1));
                else
                    cur_col_next = COL_W'(start_col_reg);
                state_next = S_INIT;
            end

            S_INIT:
            begin
                cur_cell_next = cell_calc;
                total_next    = VIS_W'(VIS_W'(act_rows_reg) * VIS_W'(act_cols_reg));
                stk_we        = 1'b1;
                stk_waddr     = '0;
                stk_cnt_next  = CNT_W'(1);
                vis_next      = VIS_W'(1);
                running_next  = 1'b1;
                done_next     = 1'b1;
                event_next    = dmc_pkg::EV_STARTED;
                to_next       = 10'(cell_calc);
                vis_out_next  = 11'd1;
                state_next    = S_IDLE;
            end

            S_READ:
            begin
                // k = 0 reads the current cell, k = 1..4 the neighbors in direction order.
                if (rd_k_reg == 3'd0)
                begin
                    wm_re = 1'b1;
                end
                else if (rd_k_reg <= 3'd4)
                begin
                    wm_re    = in_grid[2'(rd_k_reg - 3'd1)];
                    wm_raddr = nbr_addr[2'(rd_k_reg - 3'd1)];
                end
                if (rd_k_reg == 3'd1)
                    cur_walls_next = wm_rwalls;
                else if (rd_k_reg >= 3'd2)
                    mask_next[2'(rd_k_reg - 3'd2)] = in_grid[2'(rd_k_reg - 3'd2)]
                        && (wm_rwalls == dmc_pkg::ALL_WALLS);
                if (rd_k_reg == 3'd5)
                    state_next = S_DECIDE;
                else
                    rd_k_next = rd_k_reg + 3'd1;
            end

            S_DECIDE:
            begin
                if (mask_reg != 4'd0)
                begin
                    wm_we     = 1'b1;
                    wm_wwalls = cur_walls_reg & ~(4'b0001 << pick_dir);
                    if (int'(stk_cnt_reg) < STK_SLOTS)
                    begin
                        stk_we       = 1'b1;
                        stk_cnt_next = stk_cnt_reg + CNT_W'(1);
                    end
                    dir_next   = pick_dir;
                    state_next = S_WR2;
                end
                else if (stk_cnt_reg != '0)
                begin
                    stk_re       = 1'b1;
                    stk_cnt_next = stk_cnt_reg - CNT_W'(1);
                    state_next   = S_POP;
                end
                else
                begin
                    vis_next     = total_reg;
                    running_next = 1'b0;
                    done_next    = 1'b1;
                    event_next   = dmc_pkg::EV_FINISHED;
                    vis_out_next = 11'(total_reg);
                    state_next   = S_IDLE;
                end
            end

            S_WR2:
            begin
                // Picked neighbor was untouched, so its word is all walls up.
                wm_we         = 1'b1;
                wm_waddr      = nbr_addr[dir_reg];
                wm_wwalls     = dmc_pkg::ALL_WALLS & ~(4'b0001 << (dir_reg ^ 2'b01));
                cur_cell_next = nbr_addr[dir_reg];
                case (dir_reg)
                    dmc_pkg::DIR_UP:   cur_row_next = cur_row_reg - ROW_W'(1);
                    dmc_pkg::DIR_DOWN: cur_row_next = cur_row_reg + ROW_W'(1);
                    dmc_pkg::DIR_LEFT: cur_col_next = cur_col_reg - COL_W'(1);
                    default:           cur_col_next = cur_col_reg + COL_W'(1);
                endcase
                vis_next     = vis_reg + VIS_W'(1);
                done_next    = 1'b1;
                event_next   = dmc_pkg::EV_CARVED;
                to_next      = 10'(nbr_addr[dir_reg]);
                dir_out_next = dir_reg;
                vis_out_next = 11'(vis_reg + VIS_W'(1));
                state_next   = S_IDLE;
            end

            S_POP:
            begin
                cur_row_next  = calc_row;
                cur_col_next  = calc_col;
                cur_cell_next = cell_calc;
                done_next     = 1'b1;
                event_next    = dmc_pkg::EV_BACKTRACKED;
                to_next       = 10'(cell_calc);
                vis_out_next  = 11'(vis_reg);
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_rows_reg  <= 6'd8;
            num_cols_reg  <= 6'd8;
            start_row_reg <= 5'd0;
            start_col_reg <= 5'd0;
            act_rows_reg  <= RCNT_W'(MAX_ROWS);
            act_cols_reg  <= CCNT_W'(MAX_COLS);
            total_reg     <= VIS_W'(CELL_SLOTS);
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cur_cell_reg  <= '0;
            vis_reg       <= '0;
            stk_cnt_reg   <= '0;
            running_reg   <= 1'b0;
            epoch_reg     <= '0;
            clr_addr_reg  <= '0;
            rd_k_reg      <= 3'd0;
            cur_walls_reg <= dmc_pkg::ALL_WALLS;
            mask_reg      <= 4'd0;
            rnd_reg       <= 8'd0;
            dir_reg       <= dmc_pkg::DIR_UP;
            done_reg      <= 1'b0;
            event_reg     <= dmc_pkg::EV_IGNORED;
            from_reg      <= 10'd0;
            to_reg        <= 10'd0;
            dir_out_reg   <= dmc_pkg::DIR_UP;
            vis_out_reg   <= 11'd0;
        end
        else
        begin
            state_reg     <= state_next;
            num_rows_reg  <= num_rows_next;
            num_cols_reg  <= num_cols_next;
            start_row_reg <= start_row_next;
            start_col_reg <= start_col_next;
            act_rows_reg  <= act_rows_next;
            act_cols_reg  <= act_cols_next;
            total_reg     <= total_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            cur_cell_reg  <= cur_cell_next;
            vis_reg       <= vis_next;
            stk_cnt_reg   <= stk_cnt_next;
            running_reg   <= running_next;
            epoch_reg     <= epoch_next;
            clr_addr_reg  <= clr_addr_next;
            rd_k_reg      <= rd_k_next;
            cur_walls_reg <= cur_walls_next;
            mask_reg      <= mask_next;
            rnd_reg       <= rnd_next;
            dir_reg       <= dir_next;
            done_reg      <= done_next;
            event_reg     <= event_next;
            from_reg      <= from_next;
            to_reg        <= to_next;
            dir_out_reg   <= dir_out_next;
            vis_out_reg   <= vis_out_next;
        end
    end

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(stk_cnt_reg) <= STK_SLOTS)
        else $error("path stack count above capacity");

    a_vis_bound: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (vis_reg <= total_reg))
        else $error("visited count above cell count while running");

    a_carve_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR2) |=> (vis_reg == $past(vis_reg) + VIS_W'(1)))
        else $error("carve did not count one new cell");

    a_clear_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!wm_re && wm_we && wm_clear))
        else $error("wall RAM read during clearing sweep");

    a_ignored_same: assert property (@(posedge clk) disable iff (!rst_n)
        (done && event_res == dmc_pkg::EV_IGNORED) |-> (from_cell == to_cell))
        else $error("ignored request moved the current cell");

endmodule

// File: sim/tb_dfs_maze_carver_top.sv
// Self-checking testbench for the depth-first maze carver top level.
`timescale 1ns / 1ps

module tb_dfs_maze_carver_top;

    localparam int GRID_MAX_ROWS = dmc_pkg::DEF_MAX_ROWS;
    localparam int GRID_MAX_COLS = dmc_pkg::DEF_MAX_COLS;
    localparam int CELL_SLOTS    = GRID_MAX_ROWS * GRID_MAX_COLS;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int TALL_COLS     = 4;

    typedef struct packed {
        logic [2:0]  ev;
        logic [9:0]  from_c;
        logic [9:0]  to_c;
        logic [1:0]  dir;
        logic [10:0] visited;
    } move_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rnd;
    } maze_req_t;

    logic        clk;
    logic        rst_n;
    logic        start = 1'b0;
    logic        busy;
    logic        req_type = dmc_pkg::REQ_START;
    logic [7:0]  rand_value = 8'd0;
    logic        done;
    logic [2:0]  event_res;
    logic [9:0]  from_cell;
    logic [9:0]  to_cell;
    logic [1:0]  direction;
    logic [10:0] cells_visited;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;

    dfs_maze_carver_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .rand_value    (rand_value),
        .done          (done),
        .event_res     (event_res),
        .from_cell     (from_cell),
        .to_cell       (to_cell),
        .direction     (direction),
        .cells_visited (cells_visited),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Shadow of the carver: register copies, latched grid and walk state.
    int         cfg_rows = 8;
    int         cfg_cols = 8;
    int         cfg_srow = 0;
    int         cfg_scol = 0;
    int         grid_rows = GRID_MAX_ROWS;
    int         grid_cols = GRID_MAX_COLS;
    logic [3:0] walls [CELL_SLOTS];
    logic [9:0] path [CELL_SLOTS + 1];
    int         depth = 0;
    int         cur_cell = 0;
    int         visited = 0;
    bit         walking = 1'b0;

    maze_req_t  req_q [$];
    move_t      move_q [$];
    int         pending = 0;
    int         errors = 0;
    int         cycles = 0;
    bit         req_taken = 1'b0;
    bit         cfg_taken = 1'b0;
    bit         calm = 1'b0;
    int         gap_left = 0;
    int         quiet_left = 0;

    function automatic move_t next_move(input logic kind, input logic [7:0] rnd);
        move_t      m;
        int         total;
        int         row;
        int         col;
        int         cnt;
        int         pick;
        int         r;
        int         c;
        int         cand_cell [4];
        logic [1:0] cand_dir [4];
        logic [1:0] d;
        m.from_c = 10'(cur_cell);
        m.dir    = dmc_pkg::DIR_UP;
        if (kind == dmc_pkg::REQ_START)
        begin
            grid_rows = (cfg_rows < 1) ? 1
                      : ((cfg_rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : cfg_rows);
            grid_cols = (cfg_cols < 1) ? 1
                      : ((cfg_cols > GRID_MAX_COLS) ? GRID_MAX_COLS : cfg_cols);
            r = (cfg_srow > grid_rows - 1) ? grid_rows - 1 : cfg_srow;
            c = (cfg_scol > grid_cols - 1) ? grid_cols - 1 : cfg_scol;
            foreach (walls[k])
                walls[k] = dmc_pkg::ALL_WALLS;
            cur_cell = r * grid_cols + c;
            path[0] = 10'(cur_cell);
            depth = 1;
            visited = 1;
            walking = 1'b1;
            m.ev = dmc_pkg::EV_STARTED;
        end
        else if (!walking)
        begin
            m.ev = dmc_pkg::EV_IGNORED;
        end
        else
        begin
            total = grid_rows * grid_cols;
            if (visited >= total || cur_cell >= total)
            begin
                visited = total;
                walking = 1'b0;
                m.ev = dmc_pkg::EV_FINISHED;
            end
            else
            begin
                row = cur_cell / grid_cols;
                col = cur_cell % grid_cols;
                cnt = 0;
                if (row > 0 && walls[cur_cell - grid_cols] == dmc_pkg::ALL_WALLS)
                begin
                    cand_cell[cnt] = cur_cell - grid_cols;
                    cand_dir[cnt] = dmc_pkg::DIR_UP;
                    cnt++;
                end
                if (row + 1 < grid_rows && walls[cur_cell + grid_cols] == dmc_pkg::ALL_WALLS)
                begin
                    cand_cell[cnt] = cur_cell + grid_cols;
                    cand_dir[cnt] = dmc_pkg::DIR_DOWN;
                    cnt++;
                end
                if (col > 0 && walls[cur_cell - 1] == dmc_pkg::ALL_WALLS)
                begin
                    cand_cell[cnt] = cur_cell - 1;
                    cand_dir[cnt] = dmc_pkg::DIR_LEFT;
                    cnt++;
                end
                if (col + 1 < grid_cols && walls[cur_cell + 1] == dmc_pkg::ALL_WALLS)
                begin
                    cand_cell[cnt] = cur_cell + 1;
                    cand_dir[cnt] = dmc_pkg::DIR_RIGHT;
                    cnt++;
                end
                if (cnt > 0)
                begin
                    pick = int'(rnd) % cnt;
                    d = cand_dir[pick];
                    // knock down the shared wall on both sides
                    walls[cur_cell] = walls[cur_cell] & ~(4'b0001 << d);
                    walls[cand_cell[pick]] = walls[cand_cell[pick]] & ~(4'b0001 << (d ^ 2'd1));
                    if (depth < CELL_SLOTS + 1)
                    begin
                        path[depth] = 10'(cur_cell);
                        depth++;
                    end
                    cur_cell = cand_cell[pick];
                    visited++;
                    m.ev = dmc_pkg::EV_CARVED;
                    m.dir = d;
                end
                else if (depth > 0)
                begin
                    depth--;
                    cur_cell = path[depth];
                    m.ev = dmc_pkg::EV_BACKTRACKED;
                end
                else
                begin
                    visited = total;
                    walking = 1'b0;
                    m.ev = dmc_pkg::EV_FINISHED;
                end
            end
        end
        m.to_c = 10'(cur_cell);
        m.visited = 11'(visited);
        return m;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d actual %0d", $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("dfs_maze_carver_top regression: fail");
            $finish;
        end
    end

    // Monitor: check results first, then predict for the request taken at this edge.
    always @(posedge clk)
    begin
        move_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (move_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected: expected none actual event %0d",
                             $realtime, event_res);
                end
                else
                begin
                    want = move_q.pop_front();
                    check_field("event_res", want.ev, event_res);
                    check_field("from_cell", want.from_c, from_cell);
                    check_field("to_cell", want.to_c, to_cell);
                    check_field("direction", want.dir, direction);
                    check_field("cells_visited", want.visited, cells_visited);
                end
            end
            req_taken = start && !busy;
            cfg_taken = cfg_valid && cfg_ready;
            if (req_taken)
            begin
                move_q.push_back(next_move(req_type, rand_value));
                pending--;
            end
        end
    end

    // Driver: hold a request until taken, with random idle bursts.
    always @(negedge clk)
    begin
        maze_req_t item;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && !req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (!calm && quiet_left == 0 && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(1, 15) - 1;
                start <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                if (quiet_left > 0)
                    quiet_left--;
                else if ($urandom_range(0, 31) == 0)
                    quiet_left = 40;
                item = req_q.pop_front();
                start <= 1'b1;
                req_type <= item.kind;
                rand_value <= item.rnd;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    task automatic push_req(input logic kind, input logic [7:0] rnd);
        maze_req_t item;
        item.kind = kind;
        item.rnd = rnd;
        pending++;
        req_q.push_back(item);
    endtask

    task automatic push_steps(input int n);
        for (int i = 0; i < n; i++)
            push_req(dmc_pkg::REQ_STEP, 8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        case (idx)
            dmc_pkg::CFG_NUM_ROWS:  cfg_rows = data;
            dmc_pkg::CFG_NUM_COLS:  cfg_cols = data;
            dmc_pkg::CFG_START_ROW: cfg_srow = data & 6'h1F;
            default:                cfg_scol = data & 6'h1F;
        endcase
    endtask

    // Wait until every request is taken and answered, then let the block settle.
    task automatic drain();
        do
            @(negedge clk);
        while (pending != 0 || move_q.size() != 0);
        repeat (12) @(negedge clk);
    endtask

    initial
    begin
        int made;
        int n;
        int er;
        int ec;
        logic [5:0] v;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = dmc_pkg::CFG_NUM_ROWS;
        cfg_data = 6'd0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Default 8x8 grid; a step before any start is ignored.
        push_req(dmc_pkg::REQ_STEP, 8'd0);
        push_req(dmc_pkg::REQ_START, 8'hFF);
        push_req(dmc_pkg::REQ_STEP, 8'd0);
        push_req(dmc_pkg::REQ_STEP, 8'hFF);
        push_req(dmc_pkg::REQ_STEP, 8'hFF);
        push_req(dmc_pkg::REQ_STEP, 8'd0);
        drain();

        // Sizes saturate to 1x32, start cell saturates to the last column; the walk
        // in progress keeps the old grid until the next start.
        write_reg(dmc_pkg::CFG_NUM_ROWS, 6'd0);
        write_reg(dmc_pkg::CFG_NUM_COLS, 6'd63);
        write_reg(dmc_pkg::CFG_START_ROW, 6'd63);
        write_reg(dmc_pkg::CFG_START_COL, 6'd31);
        push_req(dmc_pkg::REQ_STEP, 8'hAA);
        push_req(dmc_pkg::REQ_START, 8'h55);
        push_req(dmc_pkg::REQ_STEP, 8'hFF);
        push_req(dmc_pkg::REQ_STEP, 8'd0);
        push_req(dmc_pkg::REQ_STEP, 8'h81);
        drain();

        // Single cell: finishes at once, then idle.
        write_reg(dmc_pkg::CFG_NUM_ROWS, 6'd1);
        write_reg(dmc_pkg::CFG_NUM_COLS, 6'd1);
        write_reg(dmc_pkg::CFG_START_ROW, 6'd0);
        write_reg(dmc_pkg::CFG_START_COL, 6'd0);
        push_req(dmc_pkg::REQ_START, 8'd0);
        push_req(dmc_pkg::REQ_STEP, 8'd0);
        push_req(dmc_pkg::REQ_STEP, 8'hFF);
        push_req(dmc_pkg::REQ_STEP, 8'd7);
        drain();

        // 2x2 from the far corner: carves every cell, then finishes; later steps are ignored.
        write_reg(dmc_pkg::CFG_NUM_ROWS, 6'd2);
        write_reg(dmc_pkg::CFG_NUM_COLS, 6'd2);
        write_reg(dmc_pkg::CFG_START_ROW, 6'd1);
        write_reg(dmc_pkg::CFG_START_COL, 6'd1);
        push_req(dmc_pkg::REQ_START, 8'd3);
        push_steps(8);
        drain();

        made = 0;
        while (made < 220)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                v = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(1, 6));
                write_reg(dmc_pkg::CFG_NUM_ROWS, v);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                v = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(1, 6));
                write_reg(dmc_pkg::CFG_NUM_COLS, v);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(dmc_pkg::CFG_START_ROW, 6'($urandom_range(0, 63)));
            if ($urandom_range(0, 2) == 0)
                write_reg(dmc_pkg::CFG_START_COL, 6'($urandom_range(0, 63)));
            er = (cfg_rows < 1) ? 1 : ((cfg_rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : cfg_rows);
            ec = (cfg_cols < 1) ? 1 : ((cfg_cols > GRID_MAX_COLS) ? GRID_MAX_COLS : cfg_cols);
            n = 2 * er * ec + $urandom_range(0, 2);
            if (n > 120)
                n = 120;
            // mostly a fresh walk; otherwise the previous walk carries on
            if ($urandom_range(0, 7) != 0)
                push_req(dmc_pkg::REQ_START, 8'($urandom_range(0, 255)));
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                    push_req(dmc_pkg::REQ_START, 8'($urandom_range(0, 255)));
                else
                    push_req(dmc_pkg::REQ_STEP, 8'($urandom_range(0, 255)));
            end
            made += n + 1;
            drain();
        end

        // Full-height walk, rows saturating, to completion with no idling.
        calm = 1'b1;
        write_reg(dmc_pkg::CFG_NUM_ROWS, 6'd40);
        write_reg(dmc_pkg::CFG_NUM_COLS, 6'(TALL_COLS));
        write_reg(dmc_pkg::CFG_START_ROW, 6'($urandom_range(0, 31)));
        write_reg(dmc_pkg::CFG_START_COL, 6'($urandom_range(0, 31)));
        push_req(dmc_pkg::REQ_START, 8'($urandom_range(0, 255)));
        push_steps(2 * GRID_MAX_ROWS * TALL_COLS + 2);
        drain();
        repeat (20) @(negedge clk);

        if (errors == 0)
            $display("dfs_maze_carver_top regression: pass");
        else
            $display("dfs_maze_carver_top regression: fail");
        $finish;
    end

endmodule
